// ===== rtl/segment_allocator_fit_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Segment allocator assertion macros
// Short forms for the concurrent checks used inside the allocator.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_ALLOCATOR_FIT_UNIT_ASSERT_SVH
`define SEGMENT_ALLOCATOR_FIT_UNIT_ASSERT_SVH

// Check that post holds in the same cycle as pre.
`define SAFU_ASSERT_SAME(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Check that post holds in the cycle after pre.
`define SAFU_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/safu_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment allocator package
// Field widths, codes, request/result types and controller handshake types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package safu_pkg;

   localparam int ADDR_W      = 16;
   localparam int LEN_W       = 17;
   localparam int TAG_W       = 16;
   localparam int CSR_DATA_W  = 17;
   localparam int CSR_INDEX_W = 1;

   localparam int DEFAULT_MAX_SEGMENTS = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIT_STRATEGY = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_BYTES   = 1'b1;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic FIT_FIRST = 1'b0;
   localparam logic FIT_BEST  = 1'b1;

   localparam logic [LEN_W-1:0] POOL_RESET = 17'd4096;
   localparam logic [LEN_W-1:0] POOL_MIN   = 17'd1;
   localparam logic [LEN_W-1:0] POOL_MAX   = 17'd65536;

   typedef struct packed {
      logic              mode;
      logic [LEN_W-1:0]  request_size;
      logic [ADDR_W-1:0] free_address;
      logic [TAG_W-1:0]  line_tag;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] block_address;
      logic              success;
      logic [LEN_W-1:0]  allocated_total;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [LEN_W-1:0]  length;
      logic              used;
      logic [TAG_W-1:0]  tag;
   } seg_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic decide;
      logic copy;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic copy_done;
   } sts_type;

   // Bring a written pool size into the legal range.
   function automatic logic [LEN_W-1:0] clamp_pool(input logic [LEN_W-1:0] value);
      logic [LEN_W-1:0] result;
      result = value;
      if (value == '0) begin
         result = POOL_MIN;
      end else if (value > POOL_MAX) begin
         result = POOL_MAX;
      end
      return result;
   endfunction

endpackage

// ===== rtl/safu_ctrl.sv =====
// ----------------------------------------------------------------------------
// Segment allocator controller
// Sequences scan, decision, table move and result phases of one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module safu_ctrl
   import safu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_COPY   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_COPY;
         end
         ST_COPY: begin
            cmd.copy = 1'b1;
            if (sts.copy_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/safu_datapath.sv =====
// ----------------------------------------------------------------------------
// Segment allocator datapath
// Segment table RAM, scan and pick logic, table move engine and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segment_allocator_fit_unit_assert.svh"

module safu_datapath
   import safu_pkg::*;
#(
   parameter int MAX_SEGMENTS = DEFAULT_MAX_SEGMENTS
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  req_type                req_item,
   input  cmd_type                cmd,
   output sts_type                sts,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output logic                   rsp_strobe,
   output rsp_type                rsp_item
);

   localparam int IDX_W = $clog2(MAX_SEGMENTS);
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   // segment table
   seg_type mem [MAX_SEGMENTS];
   seg_type rd_data_ff;

   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   seg_type          wr_data;

   req_type          req_ff, req_in;
   logic             fit_ff, fit_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0] total_ff, total_in;

   // scan state
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] ev_idx_ff, ev_idx_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] pick_idx_ff, pick_idx_in;
   seg_type          pick_ff, pick_in;
   seg_type          last_ff, last_in;
   seg_type          prev_ff, prev_in;
   logic             prev_vld_ff, prev_vld_in;
   seg_type          next_ff, next_in;
   logic             next_vld_ff, next_vld_in;

   // decision
   logic             ok_ff, ok_in;
   logic             split_ff, split_in;
   logic [1:0]       drop_ff, drop_in;

   // move engine
   logic [CNT_W-1:0] cp_src_ff, cp_src_in;
   logic [CNT_W-1:0] cp_left_ff, cp_left_in;
   logic             cp_up_ff, cp_up_in;
   logic [IDX_W-1:0] cp_dst_ff, cp_dst_in;
   logic             cp_wvld_ff, cp_wvld_in;

   rsp_type          rsp_ff, rsp_in;
   logic             rsp_vld_ff, rsp_vld_in;

   logic             is_alloc;
   logic             halt;
   logic             issue;
   logic             fits;
   logic             better;
   logic             match;
   logic             take;
   logic             alloc_ok;
   logic             alloc_split;
   logic             pf;
   logic             nf;
   logic [1:0]       merge_r;
   logic [IDX_W-1:0] merge_m;
   logic [LEN_W-1:0] merge_len;
   logic [CNT_W-1:0] cp_dst_wide;

   always_comb begin
      is_alloc = (req_ff.mode == MODE_ALLOC);
      halt     = found_ff && (!is_alloc || fit_ff == FIT_FIRST);
      issue    = (rd_idx_ff != cnt_ff) && !halt;

      fits   = !rd_data_ff.used && (rd_data_ff.length >= req_ff.request_size)
               && (req_ff.request_size != '0);
      better = !found_ff || (fit_ff == FIT_BEST && rd_data_ff.length < pick_ff.length);
      match  = rd_data_ff.used && (rd_data_ff.base == req_ff.free_address) && !found_ff;
      take   = is_alloc ? (fits && better) : match;

      alloc_ok    = found_ff && ((pick_ff.length == req_ff.request_size) || (cnt_ff != CNT_MAX));
      alloc_split = found_ff && (pick_ff.length != req_ff.request_size) && (cnt_ff != CNT_MAX);

      pf        = prev_vld_ff && !prev_ff.used;
      nf        = next_vld_ff && !next_ff.used;
      merge_r   = {1'b0, pf} + {1'b0, nf};
      merge_m   = pf ? (pick_idx_ff - IDX_W'(1)) : pick_idx_ff;
      merge_len = LEN_W'((pf ? prev_ff.length : '0) + pick_ff.length
                         + (nf ? next_ff.length : '0));

      cp_dst_wide = cp_up_ff ? (cp_src_ff + CNT_ONE) : (cp_src_ff - CNT_W'(drop_ff));
   end

   always_comb begin
      req_in      = req_ff;
      fit_in      = fit_ff;
      cnt_in      = cnt_ff;
      total_in    = total_ff;
      rd_idx_in   = rd_idx_ff;
      rd_vld_in   = rd_vld_ff;
      ev_idx_in   = ev_idx_ff;
      found_in    = found_ff;
      pick_idx_in = pick_idx_ff;
      pick_in     = pick_ff;
      last_in     = last_ff;
      prev_in     = prev_ff;
      prev_vld_in = prev_vld_ff;
      next_in     = next_ff;
      next_vld_in = next_vld_ff;
      ok_in       = ok_ff;
      split_in    = split_ff;
      drop_in     = drop_ff;
      cp_src_in   = cp_src_ff;
      cp_left_in  = cp_left_ff;
      cp_up_in    = cp_up_ff;
      cp_dst_in   = cp_dst_ff;
      cp_wvld_in  = cp_wvld_ff;
      rsp_in      = rsp_ff;
      rsp_vld_in  = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = rd_idx_ff[IDX_W-1:0];
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;

      if (cmd.load) begin
         req_in      = req_item;
         rd_idx_in   = '0;
         rd_vld_in   = 1'b0;
         found_in    = 1'b0;
         prev_vld_in = 1'b0;
         next_vld_in = 1'b0;
      end

      // walk the table, one entry read per cycle
      if (cmd.scan) begin
         rd_en     = issue;
         rd_vld_in = issue;
         ev_idx_in = rd_idx_ff[IDX_W-1:0];
         if (issue) begin
            rd_idx_in = rd_idx_ff + CNT_ONE;
         end
         if (rd_vld_ff) begin
            last_in = rd_data_ff;
            if (take) begin
               found_in    = 1'b1;
               pick_idx_in = ev_idx_ff;
               pick_in     = rd_data_ff;
               prev_in     = last_ff;
               prev_vld_in = (ev_idx_ff != '0);
            end else if (found_ff && !is_alloc) begin
               next_in     = rd_data_ff;
               next_vld_in = 1'b1;
            end
         end
      end

      if (cmd.decide) begin
         cp_wvld_in = 1'b0;
         cp_left_in = '0;
         split_in   = 1'b0;
         drop_in    = '0;
         if (is_alloc) begin
            ok_in = alloc_ok;
            if (alloc_ok) begin
               wr_en          = 1'b1;
               wr_addr        = pick_idx_ff;
               wr_data.base   = pick_ff.base;
               wr_data.length = req_ff.request_size;
               wr_data.used   = 1'b1;
               wr_data.tag    = req_ff.line_tag;
               total_in       = total_ff + req_ff.request_size;
            end
            if (alloc_split) begin
               split_in   = 1'b1;
               cp_up_in   = 1'b1;
               cp_src_in  = cnt_ff - CNT_ONE;
               cp_left_in = cnt_ff - CNT_ONE - CNT_W'(pick_idx_ff);
            end
         end else begin
            ok_in = found_ff;
            if (found_ff) begin
               wr_en          = 1'b1;
               wr_addr        = merge_m;
               wr_data.base   = pf ? prev_ff.base : pick_ff.base;
               wr_data.length = merge_len;
               total_in       = total_ff - pick_ff.length;
               drop_in        = merge_r;
               cp_up_in       = 1'b0;
               cp_src_in      = CNT_W'(merge_m) + CNT_W'(merge_r) + CNT_ONE;
               cp_left_in     = cnt_ff - CNT_ONE - CNT_W'(merge_m) - CNT_W'(merge_r);
            end
         end
      end

      // shift entries one place per cycle: read source, write next cycle
      if (cmd.copy) begin
         cp_wvld_in = 1'b0;
         if (cp_left_ff != '0) begin
            rd_en      = 1'b1;
            rd_addr    = cp_src_ff[IDX_W-1:0];
            cp_dst_in  = cp_dst_wide[IDX_W-1:0];
            cp_src_in  = cp_up_ff ? (cp_src_ff - CNT_ONE) : (cp_src_ff + CNT_ONE);
            cp_left_in = cp_left_ff - CNT_ONE;
            cp_wvld_in = 1'b1;
         end
         if (cp_wvld_ff) begin
            wr_en   = 1'b1;
            wr_addr = cp_dst_ff;
            wr_data = rd_data_ff;
         end
      end

      if (cmd.finish) begin
         if (split_ff) begin
            wr_en          = 1'b1;
            wr_addr        = pick_idx_ff + IDX_W'(1);
            wr_data.base   = ADDR_W'(pick_ff.base + req_ff.request_size[ADDR_W-1:0]);
            wr_data.length = pick_ff.length - req_ff.request_size;
            cnt_in         = cnt_ff + CNT_ONE;
         end else if (ok_ff && !is_alloc) begin
            cnt_in = cnt_ff - CNT_W'(drop_ff);
         end
         rsp_vld_in             = 1'b1;
         rsp_in.block_address   = (ok_ff && is_alloc) ? pick_ff.base : '0;
         rsp_in.success         = ok_ff;
         rsp_in.allocated_total = total_ff;
      end

      if (csr_write_enable) begin
         if (csr_index == CSR_FIT_STRATEGY) begin
            fit_in = csr_write_data[0];
         end else begin
            cnt_in         = CNT_ONE;
            total_in       = '0;
            wr_en          = 1'b1;
            wr_addr        = '0;
            wr_data        = '0;
            wr_data.length = clamp_pool(csr_write_data);
         end
      end

      // reset lays down the single free segment of the default pool
      if (reset) begin
         wr_en          = 1'b1;
         wr_addr        = '0;
         wr_data        = '0;
         wr_data.length = POOL_RESET;
      end
   end

   assign sts.scan_done = cmd.scan && !rd_vld_ff && (halt || rd_idx_ff == cnt_ff);
   assign sts.copy_done = cmd.copy && (cp_left_ff == '0) && !cp_wvld_ff;

   assign rsp_strobe = rsp_vld_ff;
   assign rsp_item   = rsp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_ff      <= FIT_BEST;
         cnt_ff      <= CNT_ONE;
         total_ff    <= '0;
         rd_vld_ff   <= 1'b0;
         found_ff    <= 1'b0;
         prev_vld_ff <= 1'b0;
         next_vld_ff <= 1'b0;
         ok_ff       <= 1'b0;
         split_ff    <= 1'b0;
         cp_left_ff  <= '0;
         cp_wvld_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         fit_ff      <= fit_in;
         cnt_ff      <= cnt_in;
         total_ff    <= total_in;
         rd_vld_ff   <= rd_vld_in;
         found_ff    <= found_in;
         prev_vld_ff <= prev_vld_in;
         next_vld_ff <= next_vld_in;
         ok_ff       <= ok_in;
         split_ff    <= split_in;
         cp_left_ff  <= cp_left_in;
         cp_wvld_ff  <= cp_wvld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rd_idx_ff   <= rd_idx_in;
      ev_idx_ff   <= ev_idx_in;
      pick_idx_ff <= pick_idx_in;
      pick_ff     <= pick_in;
      last_ff     <= last_in;
      prev_ff     <= prev_in;
      next_ff     <= next_in;
      drop_ff     <= drop_in;
      cp_src_ff   <= cp_src_in;
      cp_up_ff    <= cp_up_in;
      cp_dst_ff   <= cp_dst_in;
      rsp_ff      <= rsp_in;
   end

   `SAFU_ASSERT_SAME(a_cnt_range, clock, reset, 1'b1, (cnt_ff != '0) && (cnt_ff <= CNT_MAX), "segment count out of range")
   `SAFU_ASSERT_SAME(a_copy_write_in_copy, clock, reset, cp_wvld_ff, cmd.copy, "table move write outside move phase")
   `SAFU_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_vld_ff, !rsp_vld_ff, "result strobe longer than one cycle")
   `SAFU_ASSERT_SAME(a_split_room, clock, reset, cmd.finish && split_ff, cnt_ff != CNT_MAX, "split with a full table")
   `SAFU_ASSERT_SAME(a_total_bound, clock, reset, 1'b1, total_ff <= POOL_MAX, "allocated total beyond pool")

endmodule

// ===== rtl/segment_allocator_fit_unit.sv =====
// ----------------------------------------------------------------------------
// Segment allocator, first fit / best fit with coalescing
// Top level: controller and datapath of the segment table allocator.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low; busy then
// stays high while it walks the segment table and moves entries. The walk
// reads one entry per cycle through the single read port of the segment
// table RAM, and on a free it reads one entry more to fetch the following
// neighbour. Entries moved to open or close a slot go through the same port,
// one per cycle. The result is shown on rsp_item with rsp_strobe high for
// exactly one cycle, in the first cycle that busy is low again; it cannot
// be held off, so capture it there. Write configuration only while busy
// is low; a pool size write rebuilds the table at once (one table write, no
// clearing pass).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_allocator_fit_unit
   import safu_pkg::*;
#(
   parameter int MAX_SEGMENTS = DEFAULT_MAX_SEGMENTS
)
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_item,
   // result channel
   output logic                   rsp_strobe,
   output rsp_type                rsp_item,
   // configuration writes
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // commands down to the datapath, status back up
   cmd_type cmd;
   sts_type sts;

   // Sequence each request: load, walk the table, decide, move entries,
   // then drop the result on the strobe.
   safu_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // Hold the segment table, the counts and the result register.
   safu_datapath #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_item         (req_item),
      .cmd              (cmd),
      .sts              (sts),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_item         (rsp_item)
   );

endmodule

// ===== tb/tb_segment_allocator_fit_unit.sv =====
// ----------------------------------------------------------------------------
// Segment allocator testbench
// Drives allocate and free requests into the fit unit in bursts, mirrors the
// segment table in a behavioural predictor and checks every result field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_segment_allocator_fit_unit;
   import safu_pkg::*;

   localparam int SEG_MAX       = DEFAULT_MAX_SEGMENTS;
   // Worst-case busy time of one request plus some margin.
   localparam int SETTLE_CYCLES = 2 * SEG_MAX + 8;
   localparam int QUIET_LIMIT   = 1000;
   localparam int RANDOM_ITEMS  = 430;

   // Directed table rows: a request checked against the mirror, a request
   // whose result is typed in, or a register write.
   typedef enum logic [1:0] {ROW_PREDICT, ROW_KNOWN, ROW_CSR} row_kind;

   typedef struct packed {
      row_kind                kind;
      logic [CSR_INDEX_W-1:0] csr_sel;
      logic [CSR_DATA_W-1:0]  csr_val;
      req_type                req;
      rsp_type                want;
   } stim_row;

   localparam int DIRECTED_ROWS = 28;

   localparam stim_row DIRECTED [DIRECTED_ROWS] = '{
      // empty request, oversize request, whole pool taken and given back
      '{ROW_KNOWN,   CSR_FIT_STRATEGY, 17'd0, '{MODE_ALLOC, 17'd0, 16'h0000, 16'h0000},
        '{16'd0, 1'b0, 17'd0}},
      '{ROW_KNOWN,   CSR_FIT_STRATEGY, 17'd0, '{MODE_ALLOC, 17'h1FFFF, 16'hFFFF, 16'hFFFF},
        '{16'd0, 1'b0, 17'd0}},
      '{ROW_KNOWN,   CSR_FIT_STRATEGY, 17'd0, '{MODE_ALLOC, 17'd4096, 16'h0000, 16'h1234},
        '{16'd0, 1'b1, 17'd4096}},
      '{ROW_KNOWN,   CSR_FIT_STRATEGY, 17'd0, '{MODE_FREE, 17'h1FFFF, 16'h0000, 16'hFFFF},
        '{16'd0, 1'b1, 17'd0}},
      // freeing the start of a free segment, and an address never handed out
      '{ROW_KNOWN,   CSR_FIT_STRATEGY, 17'd0, '{MODE_FREE, 17'd0, 16'h0000, 16'h0000},
        '{16'd0, 1'b0, 17'd0}},
      '{ROW_KNOWN,   CSR_FIT_STRATEGY, 17'd0, '{MODE_FREE, 17'd0, 16'hFFFF, 16'h0000},
        '{16'd0, 1'b0, 17'd0}},
      // largest pool, filled in one go
      '{ROW_CSR,     CSR_POOL_BYTES, 17'd65536, '{MODE_ALLOC, 17'd0, 16'h0000, 16'h0000},
        '{16'd0, 1'b0, 17'd0}},
      '{ROW_KNOWN,   CSR_FIT_STRATEGY, 17'd0, '{MODE_ALLOC, 17'd65536, 16'h5555, 16'hA5A5},
        '{16'd0, 1'b1, 17'd65536}},
      '{ROW_KNOWN,   CSR_FIT_STRATEGY, 17'd0, '{MODE_ALLOC, 17'd1, 16'h0000, 16'h0000},
        '{16'd0, 1'b0, 17'd65536}},
      '{ROW_KNOWN,   CSR_FIT_STRATEGY, 17'd0, '{MODE_FREE, 17'd0, 16'h0000, 16'h0000},
        '{16'd0, 1'b1, 17'd0}},
      // pool size of zero is taken as one byte
      '{ROW_CSR,     CSR_POOL_BYTES, 17'd0, '{MODE_ALLOC, 17'd0, 16'h0000, 16'h0000},
        '{16'd0, 1'b0, 17'd0}},
      '{ROW_KNOWN,   CSR_FIT_STRATEGY, 17'd0, '{MODE_ALLOC, 17'd2, 16'h0000, 16'h0000},
        '{16'd0, 1'b0, 17'd0}},
      '{ROW_KNOWN,   CSR_FIT_STRATEGY, 17'd0, '{MODE_ALLOC, 17'd1, 16'hAAAA, 16'h5A5A},
        '{16'd0, 1'b1, 17'd1}},
      // oversized pool write is clamped to the largest pool
      '{ROW_CSR,     CSR_POOL_BYTES, 17'h1FFFF, '{MODE_ALLOC, 17'd0, 16'h0000, 16'h0000},
        '{16'd0, 1'b0, 17'd0}},
      // carve four blocks and punch two equal holes for a best-fit tie
      '{ROW_PREDICT, CSR_FIT_STRATEGY, 17'd0, '{MODE_ALLOC, 17'd100, 16'h0000, 16'h0001},
        '{16'd0, 1'b0, 17'd0}},
      '{ROW_PREDICT, CSR_FIT_STRATEGY, 17'd0, '{MODE_ALLOC, 17'd50, 16'h0000, 16'h0002},
        '{16'd0, 1'b0, 17'd0}},
      '{ROW_PREDICT, CSR_FIT_STRATEGY, 17'd0, '{MODE_ALLOC, 17'd100, 16'h0000, 16'h0003},
        '{16'd0, 1'b0, 17'd0}},
      '{ROW_PREDICT, CSR_FIT_STRATEGY, 17'd0, '{MODE_ALLOC, 17'd50, 16'h0000, 16'h0004},
        '{16'd0, 1'b0, 17'd0}},
      '{ROW_PREDICT, CSR_FIT_STRATEGY, 17'd0, '{MODE_FREE, 17'd0, 16'd0, 16'h0000},
        '{16'd0, 1'b0, 17'd0}},
      '{ROW_PREDICT, CSR_FIT_STRATEGY, 17'd0, '{MODE_FREE, 17'd0, 16'd150, 16'h0000},
        '{16'd0, 1'b0, 17'd0}},
      '{ROW_PREDICT, CSR_FIT_STRATEGY, 17'd0, '{MODE_ALLOC, 17'd60, 16'h0000, 16'h0005},
        '{16'd0, 1'b0, 17'd0}},
      // first fit: skip the small remainder, then merge on both sides
      '{ROW_CSR,     CSR_FIT_STRATEGY, 17'd0, '{MODE_ALLOC, 17'd0, 16'h0000, 16'h0000},
        '{16'd0, 1'b0, 17'd0}},
      '{ROW_PREDICT, CSR_FIT_STRATEGY, 17'd0, '{MODE_ALLOC, 17'd20, 16'h0000, 16'h0006},
        '{16'd0, 1'b0, 17'd0}},
      '{ROW_PREDICT, CSR_FIT_STRATEGY, 17'd0, '{MODE_ALLOC, 17'd90, 16'h0000, 16'h0007},
        '{16'd0, 1'b0, 17'd0}},
      '{ROW_PREDICT, CSR_FIT_STRATEGY, 17'd0, '{MODE_FREE, 17'd0, 16'd100, 16'h0000},
        '{16'd0, 1'b0, 17'd0}},
      '{ROW_PREDICT, CSR_FIT_STRATEGY, 17'd0, '{MODE_FREE, 17'd0, 16'd250, 16'h0000},
        '{16'd0, 1'b0, 17'd0}},
      '{ROW_CSR,     CSR_FIT_STRATEGY, 17'd1, '{MODE_ALLOC, 17'd0, 16'h0000, 16'h0000},
        '{16'd0, 1'b0, 17'd0}},
      '{ROW_CSR,     CSR_POOL_BYTES, 17'd4096, '{MODE_ALLOC, 17'd0, 16'h0000, 16'h0000},
        '{16'd0, 1'b0, 17'd0}}
   };

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_item;
   logic                   rsp_strobe;
   rsp_type                rsp_item;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   // Mirror of the allocator: configuration, segment table and total.
   logic             fit_mode;
   logic [LEN_W-1:0] pool_size;
   int               usable_pool;
   seg_type          segs [SEG_MAX];
   int               seg_count;
   logic [LEN_W-1:0] bytes_out;

   // Results owed by the block, oldest first.
   rsp_type expected_q [$];

   int mismatches     = 0;
   int results_seen   = 0;
   int requests_sent  = 0;
   int csr_writes     = 0;
   int allocs_granted = 0;
   int frees_granted  = 0;
   int refusals       = 0;
   int full_refusals  = 0;
   int peak_segments  = 1;
   int burst_left     = 0;
   int quiet_cycles   = 0;

   segment_allocator_fit_unit #(
      .MAX_SEGMENTS(SEG_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Put the mirror back to one free segment covering the clamped pool.
   function automatic void rebuild_table();
      logic [LEN_W-1:0] span;
      int               i;
      span = pool_size;
      if (span == '0) begin
         span = POOL_MIN;
      end else if (span > POOL_MAX) begin
         span = POOL_MAX;
      end
      for (i = 0; i < SEG_MAX; i++) begin
         segs[i] = '0;
      end
      segs[0].length = span;
      seg_count      = 1;
      bytes_out      = '0;
      usable_pool    = int'(span);
   endfunction

   // Drop entry k and close the gap; the vacated top entry is cleared.
   function automatic void close_slot(input int k);
      int i;
      for (i = k; i + 1 < seg_count; i++) begin
         segs[i] = segs[i + 1];
      end
      seg_count--;
      segs[seg_count] = '0;
   endfunction

   // Apply one request to the mirror and return the result it must produce.
   function automatic rsp_type predict_outcome(input req_type r);
      rsp_type outcome;
      int      i;
      int      k;
      int      pick;
      int      hit;
      bit      found;
      outcome = '0;
      if (r.mode == MODE_ALLOC) begin
         found = 1'b0;
         pick  = 0;
         if (r.request_size != '0) begin
            for (i = 0; i < seg_count; i++) begin
               if (!segs[i].used && segs[i].length >= r.request_size) begin
                  // strict less-than keeps the earliest on a best-fit tie
                  if (!found || segs[i].length < segs[pick].length) begin
                     pick  = i;
                     found = 1'b1;
                  end
                  if (fit_mode == FIT_FIRST) begin
                     break;
                  end
               end
            end
         end
         // a split into a full table refuses; no other segment is tried
         if (found && segs[pick].length != r.request_size && seg_count >= SEG_MAX) begin
            found = 1'b0;
            full_refusals++;
         end
         if (found) begin
            if (segs[pick].length != r.request_size) begin
               for (k = seg_count; k > pick + 1; k--) begin
                  segs[k] = segs[k - 1];
               end
               segs[pick + 1].base   = segs[pick].base + r.request_size[ADDR_W-1:0];
               segs[pick + 1].length = segs[pick].length - r.request_size;
               segs[pick + 1].used   = 1'b0;
               segs[pick + 1].tag    = '0;
               seg_count++;
               segs[pick].length = r.request_size;
            end
            segs[pick].used       = 1'b1;
            segs[pick].tag        = r.line_tag;
            bytes_out             = bytes_out + r.request_size;
            outcome.block_address = segs[pick].base;
            outcome.success       = 1'b1;
            allocs_granted++;
            if (seg_count > peak_segments) begin
               peak_segments = seg_count;
            end
         end else begin
            refusals++;
         end
      end else begin
         hit = -1;
         for (i = 0; i < seg_count; i++) begin
            if (segs[i].used && segs[i].base == r.free_address) begin
               hit = i;
               break;
            end
         end
         if (hit >= 0) begin
            bytes_out        = bytes_out - segs[hit].length;
            segs[hit].used   = 1'b0;
            segs[hit].tag    = '0;
            if (hit + 1 < seg_count && !segs[hit + 1].used) begin
               segs[hit].length = segs[hit].length + segs[hit + 1].length;
               close_slot(hit + 1);
            end
            if (hit > 0 && !segs[hit - 1].used) begin
               segs[hit - 1].length = segs[hit - 1].length + segs[hit].length;
               close_slot(hit);
            end
            outcome.success = 1'b1;
            frees_granted++;
         end else begin
            refusals++;
         end
      end
      outcome.allocated_total = bytes_out;
      return outcome;
   endfunction

   // Present one request, hold it until taken, then record what it owes.
   // Bursts end with a random gap; a zero gap keeps start high.
   task automatic issue_request(input req_type r, input bit typed, input rsp_type typed_rsp);
      rsp_type predicted;
      int      gap;
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      predicted = predict_outcome(r);
      expected_q.push_back(typed ? typed_rsp : predicted);
      requests_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop requesting, wait for every owed result, then let the block settle.
   task automatic drain_then_pause();
      start <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; the mirror follows once the write has landed.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] sel,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= sel;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (sel == CSR_FIT_STRATEGY) begin
         fit_mode = value[0];
      end else begin
         pool_size = value;
         rebuild_table();
      end
      csr_writes++;
      @(posedge clock);
   endtask

   // Result checker and watchdog. Outputs are sampled at the edge, before
   // the block's own updates land, so the order of processes does not matter.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               mismatches++;
               $display("%0t ns: result with none outstanding: addr %h ok %b total %h",
                        $time, rsp_item.block_address, rsp_item.success,
                        rsp_item.allocated_total);
            end else begin
               want = expected_q.pop_front();
               if (rsp_item.block_address !== want.block_address) begin
                  mismatches++;
                  $display("%0t ns: block_address expected %h, got %h",
                           $time, want.block_address, rsp_item.block_address);
               end
               if (rsp_item.success !== want.success) begin
                  mismatches++;
                  $display("%0t ns: success expected %b, got %b",
                           $time, want.success, rsp_item.success);
               end
               if (rsp_item.allocated_total !== want.allocated_total) begin
                  mismatches++;
                  $display("%0t ns: allocated_total expected %h, got %h",
                           $time, want.allocated_total, rsp_item.allocated_total);
               end
            end
         end
         // count edges where no request, result or register write moved
         if (rsp_strobe || (start && !busy) || csr_write_enable) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("tb_segment_allocator_fit_unit NOT OK");
            $finish;
         end
      end
   end

   initial begin : stimulus
      req_type          r;
      rsp_type          none;
      logic [LEN_W-1:0] new_pool;
      int               n;
      int               j;
      int               idx;
      int               pick;
      int               dice;
      int               hint;
      int               phase_len;
      int               random_sent;

      reset            = 1'b1;
      start            = 1'b0;
      req_item         = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      none             = '0;
      random_sent      = 0;

      fit_mode  = FIT_BEST;
      pool_size = POOL_RESET;
      rebuild_table();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table: extremes, clamping, tie and merge cases.
      for (n = 0; n < DIRECTED_ROWS; n++) begin
         if (DIRECTED[n].kind == ROW_CSR) begin
            drain_then_pause();
            write_register(DIRECTED[n].csr_sel, DIRECTED[n].csr_val);
         end else begin
            issue_request(DIRECTED[n].req, DIRECTED[n].kind == ROW_KNOWN, DIRECTED[n].want);
         end
      end

      // Random phases: each picks a strategy and often a fresh pool, then
      // runs a stream of mostly sensible allocates and frees against it.
      while (random_sent < RANDOM_ITEMS) begin
         drain_then_pause();
         write_register(CSR_FIT_STRATEGY, CSR_DATA_W'($urandom_range(0, 1)));
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 4))
               0: begin
                  new_pool = $urandom_range(1, 64);
               end
               1: begin
                  new_pool = $urandom_range(65, 4096);
               end
               2: begin
                  new_pool = POOL_MAX;
               end
               3: begin
                  new_pool = LEN_W'($urandom);
               end
               default: begin
                  new_pool = $urandom_range(4097, 65535);
               end
            endcase
            write_register(CSR_POOL_BYTES, new_pool);
         end
         phase_len = $urandom_range(30, 70);
         repeat (phase_len) begin
            hint = usable_pool / 6;
            if (hint < 1) begin
               hint = 1;
            end
            r.mode         = ($urandom_range(0, 99) < 55) ? MODE_ALLOC : MODE_FREE;
            r.request_size = $urandom_range(1, hint);
            r.free_address = ADDR_W'($urandom);
            r.line_tag     = TAG_W'($urandom);
            pick           = $urandom_range(0, seg_count - 1);
            dice           = $urandom_range(0, 99);
            if (r.mode == MODE_ALLOC) begin
               if (dice < 15 && !segs[pick].used) begin
                  // exact fit of an existing hole
                  r.request_size = segs[pick].length;
               end else if (dice < 20) begin
                  r.request_size = '0;
               end else if (dice < 25) begin
                  r.request_size = LEN_W'($urandom);
               end
            end else begin
               if (dice < 75) begin
                  // free a live block, searching onward from a random entry
                  for (j = 0; j < seg_count; j++) begin
                     idx = (pick + j) % seg_count;
                     if (segs[idx].used) begin
                        r.free_address = segs[idx].base;
                        break;
                     end
                  end
               end else if (dice < 85) begin
                  r.free_address = segs[pick].base;
               end
            end
            issue_request(r, 1'b0, none);
            random_sent++;
         end
      end

      drain_then_pause();

      $display("Summary: %0d requests (%0d from the directed table); %0d allocations and %0d frees granted, %0d refused (%0d on a full table).",
               requests_sent, requests_sent - random_sent, allocs_granted, frees_granted,
               refusals, full_refusals);
      $display("Summary: %0d results checked, %0d register writes, table peaked at %0d segments.",
               results_seen, csr_writes, peak_segments);
      if (mismatches == 0) begin
         $display("tb_segment_allocator_fit_unit OK");
      end else begin
         $display("tb_segment_allocator_fit_unit NOT OK");
      end
      $finish;
   end

endmodule
